[hw/rtl/pcgsg_pkg.sv]
// Shared types, constants and the output permutation of the PCG32 seed generator.
// Used by the controller, the datapath and the top level; depends on nothing else.
`default_nettype none

package pcgsg_pkg;

	localparam logic [63:0] PCG_MULT    = 64'h5851_F42D_4C95_7F2D;
	localparam logic [31:0] PCG_MULT_LO = PCG_MULT[31:0];
	localparam logic [31:0] PCG_MULT_HI = PCG_MULT[63:32];
	localparam logic [63:0] STATE_INIT  = 64'h853C_49E6_748F_EA9B;
	localparam logic [63:0] INC_INIT    = 64'hDA3E_39CB_94B9_5BDB;

	localparam int XSH_SHIFT = 18;
	localparam int XSH_DROP  = 27;
	localparam int ROT_POS   = 59;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_LEN = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load;
		logic mul;
		logic add;
		logic push_err;
		logic last;
	} pcgsg_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic len_ok;
		logic out_free;
	} pcgsg_stat_t;

	// XSH-RR output permutation of the state before the step.
	function automatic logic [31:0] xsh_rr(input logic [63:0] old);
		logic [63:0] mixed;
		logic [31:0] x;
		logic [4:0]  r;
		logic [63:0] doubled;
		mixed   = ((old >> XSH_SHIFT) ^ old) >> XSH_DROP;
		x       = mixed[31:0];
		r       = old[ROT_POS +: 5];
		doubled = {x, x} >> r;
		return doubled[31:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/pcgsg_req_if.sv]
// Request channel of the seed generator: time value and requested length.
// Depends on nothing else.
`default_nettype none

interface pcgsg_req_if;
	logic        valid;
	logic        ready;
	logic [63:0] time_value;
	logic [7:0]  seed_length;

	modport source (output valid, output time_value, output seed_length, input ready);
	modport sink   (input valid, input time_value, input seed_length, output ready);
endinterface

`default_nettype wire

[hw/rtl/pcgsg_word_if.sv]
// Result channel of the seed generator: one 32-bit seed word per transaction.
// Depends on nothing else.
`default_nettype none

interface pcgsg_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;
	logic        last_word;
	logic        status;

	modport source (output valid, output random_word, output last_word, output status,
		input ready);
	modport sink   (input valid, input random_word, input last_word, input status,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/pcgsg_cfg_if.sv]
// Configuration write channel of the seed generator: carries the mix word.
// Depends on nothing else.
`default_nettype none

interface pcgsg_cfg_if;
	logic        valid;
	logic        ready;
	logic [63:0] mix_word;

	modport source (output valid, output mix_word, input ready);
	modport sink   (input valid, input mix_word, output ready);
endinterface

`default_nettype wire

[hw/rtl/pcgsg_datapath.sv]
// Datapath of the seed generator: generator state, increment, mix word, the split
// 64-bit multiply and the output register. Depends on pcgsg_pkg.
`default_nettype none

module pcgsg_datapath import pcgsg_pkg::*; #(
	parameter int SEED_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire pcgsg_cmd_t  cmd,
	output      pcgsg_stat_t stat,
	input  wire logic [63:0] req_time,
	input  wire logic [7:0]  req_len,
	input  wire logic        cfg_we,
	input  wire logic [63:0] cfg_data,
	output      logic [31:0] out_word,
	output      logic        out_last,
	output      logic        out_status,
	output      logic        out_valid,
	input  wire logic        out_ready
);

	logic [63:0] mix_q;
	logic [63:0] state_q;
	logic [63:0] inc_q;
	logic        out_valid_q;

	logic [63:0] time_q;
	logic        len_ok_q;
	logic [63:0] prod_lo_q;
	logic [31:0] prod_x1_q;
	logic [31:0] prod_x2_q;
	logic [31:0] out_word_q;
	logic        out_last_q;
	logic        out_status_q;

	logic        len_ok;
	logic        out_free;
	logic [31:0] cross_sum;

	// A length of 256 or more can never match an eight-bit request field.
	assign len_ok    = (SEED_BYTES <= 255) && (req_len == 8'(SEED_BYTES));
	assign out_free  = !out_valid_q || out_ready;
	assign cross_sum = prod_x1_q + prod_x2_q;

	assign stat = '{len_ok: len_ok_q, out_free: out_free};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q       <= '0;
			state_q     <= STATE_INIT;
			inc_q       <= INC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mix_q <= cfg_data;
			end
			if (cmd.load) begin
				state_q <= state_q ^ time_q ^ mix_q;
				inc_q   <= inc_q ^ time_q ^ mix_q;
			end else if (cmd.add) begin
				// Low 64 bits of state * multiplier, plus the odd increment.
				state_q <= prod_lo_q + {cross_sum, 32'b0} + (inc_q | 64'd1);
			end
			if (cmd.mul || cmd.push_err) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			time_q   <= req_time;
			len_ok_q <= len_ok;
		end
		if (cmd.mul) begin
			prod_lo_q    <= 64'(state_q[31:0]) * 64'(PCG_MULT_LO);
			prod_x1_q    <= state_q[31:0] * PCG_MULT_HI;
			prod_x2_q    <= state_q[63:32] * PCG_MULT_LO;
			out_word_q   <= xsh_rr(state_q);
			out_last_q   <= cmd.last;
			out_status_q <= STATUS_OK;
		end else if (cmd.push_err) begin
			out_word_q   <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= STATUS_BAD_LEN;
		end
	end

	assign out_word   = out_word_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;
	assign out_valid  = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/pcgsg_ctrl.sv]
// Controller of the seed generator: sequences request capture, length check,
// state mixing and the multiply/add pair of each word. Depends on pcgsg_pkg.
`default_nettype none

module pcgsg_ctrl import pcgsg_pkg::*; #(
	parameter int SEED_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output      logic        req_ready,
	output      pcgsg_cmd_t  cmd,
	input  wire pcgsg_stat_t stat
);

	localparam int WORDS = SEED_BYTES / 4;
	localparam int CW    = $clog2(WORDS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_ADD
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          last;

	assign last      = (cnt_q == CW'(1));
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && req_valid;
		cmd.load     = (state_q == S_CHECK) && stat.len_ok;
		cmd.push_err = (state_q == S_CHECK) && !stat.len_ok && stat.out_free;
		cmd.mul      = (state_q == S_MUL) && stat.out_free;
		cmd.add      = (state_q == S_ADD);
		cmd.last     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.len_ok) begin
						cnt_q   <= CW'(WORDS);
						state_q <= S_MUL;
					end else if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					if (stat.out_free) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					cnt_q <= cnt_q - CW'(1);
					if (last) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pcg32_seed_generator.sv]
// Top level of the PCG32 seed generator: joins the controller and the datapath.
// Depends on pcgsg_pkg, pcgsg_req_if, pcgsg_word_if, pcgsg_cfg_if and both submodules.
//
// Usage: each transaction on req carries a time value and a requested length in
// bytes. A length other than SEED_BYTES gives one word transaction with
// random_word 0, last_word 1 and status 1, and changes no state. A correct length
// mixes the time value and the mix word into the state and increment, then gives
// SEED_BYTES/4 word transactions, the final one with last_word set.
// The cfg channel writes the mix word; it is always ready and should only be used
// while no request is in flight.
// Sequencing: a request is taken in S_IDLE and checked in the next cycle, in
// S_CHECK. Each word then passes through S_MUL, which registers the output word and
// the three 32x32 partial-product multipliers, and S_ADD, the 64-bit state add; no
// new request is taken until the last word of a good request has passed S_ADD.
// A single output register holds the current word; while the receiver stalls the
// generator waits in front of it. Reset restores the published initial state and
// increment and clears the mix word; req.ready is already high as reset is released.
`default_nettype none

module pcg32_seed_generator import pcgsg_pkg::*; #(
	parameter int SEED_BYTES = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	pcgsg_req_if.sink  req,
	pcgsg_word_if.source word,
	pcgsg_cfg_if.sink  cfg
);

	pcgsg_cmd_t  cmd;
	pcgsg_stat_t stat;

	assign cfg.ready = 1'b1;

	pcgsg_ctrl #(
		.SEED_BYTES (SEED_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	pcgsg_datapath #(
		.SEED_BYTES (SEED_BYTES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_time   (req.time_value),
		.req_len    (req.seed_length),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.mix_word),
		.out_word   (word.random_word),
		.out_last   (word.last_word),
		.out_status (word.status),
		.out_valid  (word.valid),
		.out_ready  (word.ready)
	);

endmodule

`default_nettype wire
